/* src/msp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants
// Distance width, the unreachable code, item modes and the queued command.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int DW = 20;
  localparam logic [DW-1:0] UNREACH = 20'd1000000;

  // Item modes, in the encoding of the mode field.
  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_EDGE  = 3'd1,
    OP_SRC   = 3'd2,
    OP_DST   = 3'd3,
    OP_RUN   = 3'd4
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  node_a;
    logic [7:0]  node_b;
    logic [15:0] weight;
  } cmd_t;

  // Write side of the command queue.
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  // Read side of the command queue.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_rd_t;

  localparam int QDEPTH = 4;

endpackage
`default_nettype wire

/* src/msp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msp_in_if / msp_out_if: item channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface msp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [7:0]  node_a;
  logic [7:0]  node_b;
  logic [15:0] weight;
  modport source (output valid, output mode, output node_a, output node_b,
                  output weight, input ready);
  modport sink (input valid, input mode, input node_a, input node_b,
                input weight, output ready);
endinterface

interface msp_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] min_distance;
  logic        reachable;
  modport source (output valid, output min_distance, output reachable, input ready);
  modport sink (input valid, input min_distance, input reachable, output ready);
endinterface
`default_nettype wire

/* src/multi_source_shortest_path_core.sv */
// A source or destination mark is written from idle; an edge item reads the stored cost
// and, when lower, writes both directions. A clear writes one cost-matrix entry per cycle
// over all 2**(2*ceil(log2(NODES))) entries. A run loads row zero, then scans and relaxes
// once per settled node, through the cost matrix's single read port; one result follows.
// Reset: synchronous; afterwards the matrix wipe runs the same length as a clear, and no
// item is taken until it ends. A 4-entry queue holds items while the engine is busy.
`default_nettype none
// ----------------------------------------------------------------------------
// multi_source_shortest_path_core: shortest path from marked sources
// Dense-matrix Dijkstra from a virtual start node linked to every source.
// ----------------------------------------------------------------------------
module multi_source_shortest_path_core #(
  parameter int NODES = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  msp_in_if.sink    in_ch,
  msp_out_if.source out_ch
);
  import msp_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  pop;
  logic  boot;

  // Intake and classification.
  msp_front #(.NODES(NODES)) u_front (
    .in_ch  (in_ch),
    .boot   (boot),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  // Queue between intake and engine.
  msp_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (pop),
    .q_rd  (q_rd),
    .full  (q_full)
  );

  // Graph store and search.
  msp_back #(.NODES(NODES)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .pop    (pop),
    .boot   (boot),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

/* src/msp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msp_front: item intake
// Accepts items, drops unused modes and zero or out-of-range nodes, and queues the rest.
// ----------------------------------------------------------------------------
module msp_front #(
  parameter int NODES = 256
) (
  msp_in_if.sink        in_ch,
  input  logic          boot,
  input  logic          q_full,
  output msp_pkg::q_wr_t q_wr
);
  import msp_pkg::*;

  logic a_ok;
  logic b_ok;
  logic take;

  // A node is usable when it is nonzero and inside the graph.
  assign a_ok = (in_ch.node_a != 8'd0) && (32'(in_ch.node_a) < 32'(NODES));
  assign b_ok = (in_ch.node_b != 8'd0) && (32'(in_ch.node_b) < 32'(NODES));

  // No item is taken during the wipe after reset.
  assign in_ch.ready = !q_full && !boot;
  assign take        = in_ch.valid && in_ch.ready;

  // Classify the item and build the command.
  always_comb begin
    q_wr.push        = 1'b0;
    q_wr.cmd.op      = OP_CLEAR;
    q_wr.cmd.node_a  = in_ch.node_a;
    q_wr.cmd.node_b  = in_ch.node_b;
    q_wr.cmd.weight  = in_ch.weight;
    unique case (in_ch.mode)
      OP_CLEAR: begin
        q_wr.push   = take;
        q_wr.cmd.op = OP_CLEAR;
      end
      OP_EDGE: begin
        q_wr.push   = take && a_ok && b_ok;
        q_wr.cmd.op = OP_EDGE;
      end
      OP_SRC: begin
        q_wr.push   = take && a_ok;
        q_wr.cmd.op = OP_SRC;
      end
      OP_DST: begin
        q_wr.push   = take && a_ok;
        q_wr.cmd.op = OP_DST;
      end
      OP_RUN: begin
        q_wr.push   = take;
        q_wr.cmd.op = OP_RUN;
      end
      default: q_wr.push = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

/* src/msp_cmd_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msp_cmd_fifo: command queue
// A short queue that lets the intake and the search engine stall apart.
// ----------------------------------------------------------------------------
module msp_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  msp_pkg::q_wr_t q_wr,
  input  logic           pop,
  output msp_pkg::q_rd_t q_rd,
  output logic           full
);
  import msp_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  cmd_t            mem_r [QDEPTH];
  logic [PW-1:0]   wp_r, wp_nxt;
  logic [PW-1:0]   rp_r, rp_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  logic            do_pop;

  assign full       = (cnt_r == (PW+1)'(QDEPTH));
  assign q_rd.valid = (cnt_r != '0);
  assign q_rd.cmd   = mem_r[rp_r];
  assign do_pop     = pop && q_rd.valid;

  // Pointer and fill count update.
  always_comb begin
    wp_nxt  = q_wr.push ? wp_r + PW'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + PW'(1) : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(q_wr.push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wp_r] <= q_wr.cmd;
    end
  end

endmodule
`default_nettype wire

/* src/msp_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msp_back: graph store and search engine
// Holds the cost matrix and runs dense Dijkstra one entry per cycle within a pass; the result waits on out_ch.ready.
// ----------------------------------------------------------------------------
module msp_back #(
  parameter int NODES = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  msp_pkg::q_rd_t q_rd,
  output logic           pop,
  output logic           boot,
  msp_out_if.source      out_ch
);
  import msp_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam int SW = 2 * AW;
  localparam logic [AW-1:0] LAST = AW'(NODES - 1);
  localparam logic [AW-1:0] FIRST = AW'(1);

  typedef enum logic [9:0] {
    S_WIPE     = 10'b0000000001,
    S_IDLE     = 10'b0000000010,
    S_EDGE_RD  = 10'b0000000100,
    S_EDGE_CMP = 10'b0000001000,
    S_EDGE_SYM = 10'b0000010000,
    S_INIT     = 10'b0000100000,
    S_SCAN     = 10'b0001000000,
    S_SETTLE   = 10'b0010000000,
    S_RELAX    = 10'b0100000000,
    S_FINAL    = 10'b1000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [SW-1:0]   sweep_r, sweep_nxt;
  logic [AW-1:0]   j_r, j_nxt;
  logic            idone_r, idone_nxt;
  logic            rv_r, rv_nxt;
  logic [AW-1:0]   rj_r, rj_nxt;
  logic [DW-1:0]   best_r, best_nxt;
  logic [AW-1:0]   pick_r, pick_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic            boot_r, boot_nxt;
  logic            out_vld_r;
  logic [DW-1:0]   out_dist_r;
  logic            out_reach_r;
  logic            load;

  // Memories: cost matrix, distance with settled flag on top, destination marks.
  logic [DW-1:0]   ecost_r [2**SW];
  logic [DW:0]     dist_r  [2**AW];
  logic            dest_r  [2**AW];
  logic [DW-1:0]   ec_rd_r;
  logic [DW:0]     dm_rd_r;
  logic            ds_rd_r;

  logic            ec_we;
  logic [SW-1:0]   ec_wa, ec_ra;
  logic [DW-1:0]   ec_wd;
  logic            dm_we;
  logic [AW-1:0]   dm_wa;
  logic [DW:0]     dm_wd;
  logic            ds_we;
  logic [AW-1:0]   ds_wa;
  logic            ds_wd;

  logic [AW-1:0]   na, nb, qa;
  logic            loop_st;
  logic            last_in;
  logic [DW:0]     sum;
  logic [DW-1:0]   sat;

  assign na      = AW'(cmd_r.node_a);
  assign nb      = AW'(cmd_r.node_b);
  assign qa      = AW'(q_rd.cmd.node_a);
  assign loop_st = (state_r == S_INIT) || (state_r == S_SCAN) ||
                   (state_r == S_RELAX) || (state_r == S_FINAL);
  assign last_in = rv_r && (rj_r == LAST);
  assign sum     = {1'b0, best_r} + {1'b0, ec_rd_r};
  assign sat     = (sum > {1'b0, UNREACH}) ? UNREACH : sum[DW-1:0];
  assign boot    = boot_r;

  // Sequencer for every command.
  always_comb begin
    state_nxt = state_r;
    sweep_nxt = sweep_r;
    j_nxt     = j_r;
    idone_nxt = idone_r;
    rv_nxt    = 1'b0;
    rj_nxt    = j_r;
    best_nxt  = best_r;
    pick_nxt  = pick_r;
    cmd_nxt   = cmd_r;
    boot_nxt  = boot_r;
    pop       = 1'b0;
    load      = 1'b0;
    ec_we     = 1'b0;
    ec_wa     = '0;
    ec_wd     = UNREACH;
    ec_ra     = {{AW{1'b0}}, j_r};
    dm_we     = 1'b0;
    dm_wa     = rj_r;
    dm_wd     = '0;
    ds_we     = 1'b0;
    ds_wa     = '0;
    ds_wd     = 1'b0;

    // Loop states issue one read a cycle until the last node.
    if (loop_st && !idone_r) begin
      rv_nxt = 1'b1;
      rj_nxt = j_r;
      if (j_r == LAST) begin
        idone_nxt = 1'b1;
      end else begin
        j_nxt = j_r + AW'(1);
      end
    end

    unique case (state_r)
      S_WIPE: begin
        ec_we     = 1'b1;
        ec_wa     = sweep_r;
        ds_we     = 1'b1;
        ds_wa     = sweep_r[AW-1:0];
        sweep_nxt = sweep_r + SW'(1);
        if (sweep_r == '1) begin
          state_nxt = S_IDLE;
          boot_nxt  = 1'b0;
        end
      end
      S_IDLE: begin
        if (q_rd.valid) begin
          pop     = 1'b1;
          cmd_nxt = q_rd.cmd;
          case (q_rd.cmd.op)
            OP_CLEAR: begin
              sweep_nxt = '0;
              state_nxt = S_WIPE;
            end
            OP_EDGE: state_nxt = S_EDGE_RD;
            OP_SRC: begin
              ec_we = 1'b1;
              ec_wa = {{AW{1'b0}}, qa};
              ec_wd = '0;
            end
            OP_DST: begin
              ds_we = 1'b1;
              ds_wa = qa;
              ds_wd = 1'b1;
            end
            OP_RUN: begin
              j_nxt     = FIRST;
              idone_nxt = 1'b0;
              state_nxt = S_INIT;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_EDGE_RD: begin
        ec_ra     = {na, nb};
        state_nxt = S_EDGE_CMP;
      end
      S_EDGE_CMP: begin
        if ({4'b0, cmd_r.weight} < ec_rd_r) begin
          ec_we     = 1'b1;
          ec_wa     = {na, nb};
          ec_wd     = {4'b0, cmd_r.weight};
          state_nxt = S_EDGE_SYM;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EDGE_SYM: begin
        ec_we     = 1'b1;
        ec_wa     = {nb, na};
        ec_wd     = {4'b0, cmd_r.weight};
        state_nxt = S_IDLE;
      end
      S_INIT: begin
        // Copy row zero into the distance store, all unsettled.
        ec_ra = {{AW{1'b0}}, j_r};
        if (rv_r) begin
          dm_we = 1'b1;
          dm_wd = {1'b0, ec_rd_r};
        end
        if (last_in) begin
          j_nxt     = FIRST;
          idone_nxt = 1'b0;
          best_nxt  = UNREACH;
          pick_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Find the first unsettled node of least distance.
        if (rv_r && !dm_rd_r[DW] && (dm_rd_r[DW-1:0] < best_r)) begin
          best_nxt = dm_rd_r[DW-1:0];
          pick_nxt = rj_r;
        end
        if (last_in) begin
          j_nxt     = FIRST;
          idone_nxt = 1'b0;
          if (pick_nxt == '0) begin
            best_nxt  = UNREACH;
            state_nxt = S_FINAL;
          end else begin
            state_nxt = S_SETTLE;
          end
        end
      end
      S_SETTLE: begin
        dm_we     = 1'b1;
        dm_wa     = pick_r;
        dm_wd     = {1'b1, best_r};
        state_nxt = S_RELAX;
      end
      S_RELAX: begin
        // Relax every edge out of the picked node.
        ec_ra = {pick_r, j_r};
        if (rv_r && (sat < dm_rd_r[DW-1:0])) begin
          dm_we = 1'b1;
          dm_wd = {dm_rd_r[DW], sat};
        end
        if (last_in) begin
          j_nxt     = FIRST;
          idone_nxt = 1'b0;
          best_nxt  = UNREACH;
          pick_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_FINAL: begin
        // Least distance over the marked destinations, then the result.
        if (rv_r && ds_rd_r && (dm_rd_r[DW-1:0] < best_r)) begin
          best_nxt = dm_rd_r[DW-1:0];
        end
        if (idone_r && !rv_r && (!out_vld_r || out_ch.ready)) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end else if (idone_r && !rv_r) begin
          state_nxt = S_FINAL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WIPE;
      sweep_r <= '0;
      boot_r  <= 1'b1;
      j_r     <= FIRST;
      idone_r <= 1'b0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      boot_r  <= boot_nxt;
      j_r     <= j_nxt;
      idone_r <= idone_nxt;
      rv_r    <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rj_r   <= rj_nxt;
    best_r <= best_nxt;
    pick_r <= pick_nxt;
    cmd_r  <= cmd_nxt;
  end

  // Memory ports, read data registered.
  always_ff @(posedge clk) begin
    if (ec_we) begin
      ecost_r[ec_wa] <= ec_wd;
    end
    ec_rd_r <= ecost_r[ec_ra];
  end

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dist_r[dm_wa] <= dm_wd;
    end
    dm_rd_r <= dist_r[j_r];
  end

  always_ff @(posedge clk) begin
    if (ds_we) begin
      dest_r[ds_wa] <= ds_wd;
    end
    ds_rd_r <= dest_r[j_r];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_dist_r  <= best_r;
      out_reach_r <= (best_r < UNREACH);
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.min_distance = out_dist_r;
  assign out_ch.reachable    = out_reach_r;

  // A settle step always has a real node picked.
  a_settle_pick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SETTLE) |-> (pick_r != '0))
    else $error("settle without a picked node");

  // A result appears only at the end of the destination pass.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == S_FINAL))
    else $error("result raised outside the final pass");

  // The boot wipe ends only from the wipe state.
  a_boot_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(boot_r) |-> ($past(state_r == S_WIPE) && (state_r == S_IDLE)))
    else $error("boot flag dropped outside the wipe");

  // Commands leave the queue only while idle.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> ((state_r == S_IDLE) && q_rd.valid))
    else $error("queue popped while busy");

endmodule
`default_nettype wire
